/* src/running_mean_variance_stats_top_macros.svh */
// assertion macros for the running mean and variance statistics block
`ifndef RUNNING_MEAN_VARIANCE_STATS_TOP_MACROS_SVH
`define RUNNING_MEAN_VARIANCE_STATS_TOP_MACROS_SVH

// same-cycle implication
`define RMVS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RMVS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/rmvs_pkg.sv */
// widths and limits for the running mean and variance statistics block
package rmvs_pkg;

  localparam int unsigned SampleBits = 16;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned CountBits  = 32;
  localparam int unsigned SumBits    = 48;
  localparam int unsigned MeanBits   = 32;
  localparam int unsigned DevBits    = 64;
  localparam int unsigned StdBits    = 32;
  localparam int unsigned StepBits   = 5;

  localparam logic [StepBits-1:0]  StepLast = '1;
  localparam logic [CountBits-1:0] CountMax = '1;

endpackage

/* src/running_mean_variance_stats_top.sv */
// running count, min, max, sum, mean and standard deviation of signed samples
// each request runs a mean division, a deviation update, a variance division and a
// square root (saturated when too large), on a shared 2-bit-per-cycle divider and a
// 1-bit-per-cycle square root; the first request and a full count skip the mean division
// and update, a zero deviation term skips the multiply; a new request waits for the result
// asynchronous active-low reset clears all statistics to zero and the output to empty
`include "running_mean_variance_stats_top_macros.svh"

module running_mean_variance_stats_top (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [rmvs_pkg::SampleBits-1:0]  sample_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic        [rmvs_pkg::CountBits-1:0]   sample_count_o,
  output logic signed [rmvs_pkg::SampleBits-1:0]  minimum_o,
  output logic signed [rmvs_pkg::SampleBits-1:0]  maximum_o,
  output logic signed [rmvs_pkg::SumBits-1:0]     total_o,
  output logic signed [rmvs_pkg::MeanBits-1:0]    mean_o,
  output logic        [rmvs_pkg::StdBits-1:0]     std_dev_o
);
  import rmvs_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MDIV  = 4'd1;
  localparam logic [3:0] S_SECND = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_ACC   = 4'd4;
  localparam logic [3:0] S_VDIV  = 4'd5;
  localparam logic [3:0] S_SQCHK = 4'd6;
  localparam logic [3:0] S_SQRT  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  // statistics state
  logic [3:0]                 state_q, state_d;
  logic [CountBits-1:0]       count_q, count_d;
  logic signed [SampleBits-1:0] min_q, min_d, max_q, max_d;
  logic signed [SumBits-1:0]  sum_q, sum_d;
  logic signed [MeanBits-1:0] mean_q, mean_d;
  logic [DevBits-1:0]         dev_q, dev_d;
  logic                       out_valid_q, out_valid_d;

  // work registers
  logic signed [SampleBits-1:0] x_q, x_d;
  logic signed [MeanBits:0]   delta_q, delta_d;
  logic                       sneg_q, sneg_d;
  logic                       neg_q, neg_d;
  logic [DevBits-1:0]         num_q, num_d;
  logic [33:0]                rem_q, rem_d;
  logic [StdBits-1:0]         root_q, root_d;
  logic [StepBits-1:0]        cnt_q, cnt_d;
  logic [2*MeanBits-1:0]      prod_q, prod_d;
  logic                       out_load;

  // combinational helpers
  logic signed [MeanBits-1:0] smp_fix, x_fix;
  logic [SumBits:0]           sum_ext;
  logic [SumBits-1:0]         sum_new, sum_mag;
  logic signed [MeanBits:0]   delta_new, second;
  logic [32:0]                ds1, ds2;
  logic [MeanBits-1:0]        mean_sat, da, sa;
  logic [SumBits-1:0]         term;
  logic [DevBits:0]           dev_add;
  logic [DevBits-1:0]         dev_new;
  logic [35:0]                sq_rem, sq_trial;

  function automatic logic [32:0] div_step(logic [31:0] r, logic b, logic [31:0] d);
    logic [32:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      div_step = {1'b1, 32'(t - {1'b0, d})};
    end else begin
      div_step = {1'b0, t[31:0]};
    end
  endfunction

  assign smp_fix   = {sample_i, {FracBits{1'b0}}};
  assign x_fix     = {x_q, {FracBits{1'b0}}};
  assign sum_ext   = {sum_q[SumBits-1], sum_q}
                   + {{(SumBits+1-SampleBits){sample_i[SampleBits-1]}}, sample_i};
  assign delta_new = {smp_fix[MeanBits-1], smp_fix} - {mean_q[MeanBits-1], mean_q};

  always_comb begin
    if (sum_ext[SumBits] != sum_ext[SumBits-1]) begin
      sum_new = sum_ext[SumBits] ? {1'b1, {(SumBits-1){1'b0}}} : {1'b0, {(SumBits-1){1'b1}}};
    end else begin
      sum_new = sum_ext[SumBits-1:0];
    end
  end

  assign sum_mag = sum_new[SumBits-1] ? (SumBits'(0) - sum_new) : sum_new;

  // two restoring division steps per cycle
  assign ds1 = div_step(rem_q[31:0], num_q[DevBits-1], count_q);
  assign ds2 = div_step(ds1[31:0], num_q[DevBits-2], count_q);

  // saturate the mean quotient to the signed range
  always_comb begin
    if (sneg_q) begin
      mean_sat = (num_q > 64'h8000_0000) ? 32'h8000_0000 : (32'(0) - num_q[31:0]);
    end else begin
      mean_sat = (num_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : num_q[31:0];
    end
  end

  assign second = {x_fix[MeanBits-1], x_fix} - {mean_sat[MeanBits-1], mean_sat};
  assign da     = delta_q[MeanBits] ? MeanBits'(-delta_q) : delta_q[MeanBits-1:0];
  assign sa     = second[MeanBits] ? MeanBits'(-second) : second[MeanBits-1:0];

  assign term    = prod_q[2*MeanBits-1:FracBits];
  assign dev_add = {1'b0, dev_q} + {{(DevBits+1-SumBits){1'b0}}, term};

  always_comb begin
    if (neg_q) begin
      dev_new = ({{(DevBits-SumBits){1'b0}}, term} > dev_q) ? '0
              : dev_q - {{(DevBits-SumBits){1'b0}}, term};
    end else begin
      dev_new = dev_add[DevBits] ? '1 : dev_add[DevBits-1:0];
    end
  end

  // one square root digit per cycle
  assign sq_rem   = {rem_q, num_q[DevBits-1:DevBits-2]};
  assign sq_trial = {2'b00, root_q, 2'b01};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    min_d       = min_q;
    max_d       = max_q;
    sum_d       = sum_q;
    mean_d      = mean_q;
    dev_d       = dev_q;
    x_d         = x_q;
    delta_d     = delta_q;
    sneg_d      = sneg_q;
    neg_d       = neg_q;
    num_d       = num_q;
    rem_d       = rem_q;
    root_d      = root_q;
    cnt_d       = cnt_q;
    prod_d      = prod_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          x_d   = sample_i;
          rem_d = '0;
          cnt_d = '0;
          if (count_q == '0) begin
            min_d   = sample_i;
            max_d   = sample_i;
            sum_d   = {{(SumBits-SampleBits){sample_i[SampleBits-1]}}, sample_i};
            mean_d  = smp_fix;
            count_d = CountBits'(1);
            num_d   = dev_q;
            state_d = S_VDIV;
          end else if (count_q == CountMax) begin
            num_d   = dev_q;
            state_d = S_VDIV;
          end else begin
            if (sample_i < min_q) min_d = sample_i;
            if (sample_i > max_q) max_d = sample_i;
            sum_d   = sum_new;
            sneg_d  = sum_new[SumBits-1];
            count_d = count_q + CountBits'(1);
            delta_d = delta_new;
            num_d   = {sum_mag, {FracBits{1'b0}}};
            state_d = S_MDIV;
          end
        end
      end
      S_MDIV, S_VDIV: begin
        num_d = {num_q[DevBits-3:0], ds1[32], ds2[32]};
        rem_d = {2'b00, ds2[31:0]};
        cnt_d = cnt_q + StepBits'(1);
        if (cnt_q == StepLast) begin
          state_d = (state_q == S_MDIV) ? S_SECND : S_SQCHK;
        end
      end
      S_SECND: begin
        mean_d = mean_sat;
        neg_d  = delta_q[MeanBits] ^ second[MeanBits];
        num_d  = {da, sa};
        if (delta_q == '0 || second == '0) begin
          num_d   = dev_q;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = S_VDIV;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = num_q[DevBits-1:MeanBits] * num_q[MeanBits-1:0];
        state_d = S_ACC;
      end
      S_ACC: begin
        dev_d   = dev_new;
        num_d   = dev_new;
        rem_d   = '0;
        cnt_d   = '0;
        state_d = S_VDIV;
      end
      S_SQCHK: begin
        rem_d = '0;
        cnt_d = '0;
        if (num_q[DevBits-1:DevBits-FracBits] != '0) begin
          root_d  = '1;
          state_d = S_DONE;
        end else begin
          root_d  = '0;
          num_d   = {num_q[DevBits-FracBits-1:0], {FracBits{1'b0}}};
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        num_d = {num_q[DevBits-3:0], 2'b00};
        cnt_d = cnt_q + StepBits'(1);
        if (sq_rem >= sq_trial) begin
          rem_d  = 34'(sq_rem - sq_trial);
          root_d = {root_q[StdBits-2:0], 1'b1};
        end else begin
          rem_d  = sq_rem[33:0];
          root_d = {root_q[StdBits-2:0], 1'b0};
        end
        if (cnt_q == StepLast) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      min_q       <= '0;
      max_q       <= '0;
      sum_q       <= '0;
      mean_q      <= '0;
      dev_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      min_q       <= min_d;
      max_q       <= max_d;
      sum_q       <= sum_d;
      mean_q      <= mean_d;
      dev_q       <= dev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    delta_q <= delta_d;
    sneg_q  <= sneg_d;
    neg_q   <= neg_d;
    num_q   <= num_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    cnt_q   <= cnt_d;
    prod_q  <= prod_d;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sample_count_o <= count_q;
      minimum_o      <= min_q;
      maximum_o      <= max_q;
      total_o        <= sum_q;
      mean_o         <= mean_q;
      std_dev_o      <= root_q;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  `RMVS_ASSERT_IMP(min_le_max_a, clk_i, rst_ni, count_q != '0, min_q <= max_q, "min above max")
  `RMVS_ASSERT_NXT(busy_after_req_a, clk_i, rst_ni, in_valid_i && in_ready_o, state_q != S_IDLE, "idle after request")
  `RMVS_ASSERT_NXT(count_mono_a, clk_i, rst_ni, 1'b1, count_q >= $past(count_q), "count went down")
  `RMVS_ASSERT_IMP(out_from_done_a, clk_i, rst_ni, $rose(out_valid_o), $past(state_q) == S_DONE, "result not from done")

endmodule

/* tb/tb.sv */
// self-checking testbench for the running mean and variance statistics block
module tb;
  import rmvs_pkg::*;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned TailCycles = 150;
  localparam int unsigned CalmFirst  = 250;
  localparam int unsigned CalmLast   = 370;
  localparam int unsigned RandomSamples = 600;

  typedef struct {
    logic        [CountBits-1:0]  count;
    logic signed [SampleBits-1:0] lo;
    logic signed [SampleBits-1:0] hi;
    logic signed [SumBits-1:0]    total;
    logic signed [MeanBits-1:0]   mean;
    logic        [StdBits-1:0]    std_dev;
  } stats_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic signed [SampleBits-1:0] sample_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic        [CountBits-1:0]  sample_count_o;
  logic signed [SampleBits-1:0] minimum_o;
  logic signed [SampleBits-1:0] maximum_o;
  logic signed [SumBits-1:0]    total_o;
  logic signed [MeanBits-1:0]   mean_o;
  logic        [StdBits-1:0]    std_dev_o;

  logic signed [SampleBits-1:0] samples_pending[$];
  stats_t                       stats_due[$];

  int unsigned samples_sent = 0;
  int unsigned stats_checked = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // running statistics tracked alongside the block
  longint unsigned run_count = 0;
  longint          run_min = 0;
  longint          run_max = 0;
  longint          run_sum = 0;
  longint          run_mean = 0;
  longint unsigned run_dev = 0;

  running_mean_variance_stats_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_count_o (sample_count_o),
    .minimum_o      (minimum_o),
    .maximum_o      (maximum_o),
    .total_o        (total_o),
    .mean_o         (mean_o),
    .std_dev_o      (std_dev_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint clamp_mean(bit neg, longint unsigned mag);
    if (neg) begin
      return (mag > 64'd2147483648) ? -64'sd2147483648 : -longint'(mag);
    end
    return (mag > 64'd2147483647) ? 64'sd2147483647 : longint'(mag);
  endfunction

  function automatic longint mean_of(longint total, longint unsigned n);
    bit neg;
    longint unsigned mag, q, r, m;
    neg = total < 0;
    mag = neg ? -total : total;
    if (n == 0) return 0;
    q = mag / n;
    r = mag % n;
    if (q > (64'd1 << 39)) q = 64'd1 << 39;
    m = (q << FracBits) + ((r << FracBits) / n);
    return clamp_mean(neg, m);
  endfunction

  function automatic longint unsigned scaled_product(longint unsigned a, longint unsigned b);
    bit [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> FracBits;
    if (p[127:64] != 0) return '1;
    return p[63:0];
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= root + b) begin
        x -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic stats_t welford_absorb(logic signed [SampleBits-1:0] x);
    longint          xv, xq, delta, second;
    longint unsigned da, sa, term, v;
    bit              neg;
    stats_t          s;
    xv = longint'(x);
    xq = xv <<< FracBits;
    if (run_count == 0) begin
      run_min = xv;
      run_max = xv;
      run_sum = xv;
      run_mean = xq;
      run_count = 1;
    end else if (run_count < {32'd0, CountMax}) begin
      if (xv < run_min) run_min = xv;
      if (xv > run_max) run_max = xv;
      run_sum += xv;
      if (run_sum > (64'sd1 <<< 47) - 1) run_sum = (64'sd1 <<< 47) - 1;
      if (run_sum < -(64'sd1 <<< 47)) run_sum = -(64'sd1 <<< 47);
      run_count++;
      delta = xq - run_mean;
      run_mean = mean_of(run_sum, run_count);
      second = xq - run_mean;
      if (delta != 0 && second != 0) begin
        neg = (delta < 0) != (second < 0);
        da = (delta < 0) ? -delta : delta;
        sa = (second < 0) ? -second : second;
        term = scaled_product(da, sa);
        if (neg) run_dev = (term > run_dev) ? 64'd0 : run_dev - term;
        else run_dev = (term > ~run_dev) ? '1 : run_dev + term;
      end
    end
    v = run_dev / run_count;
    s.count = run_count[CountBits-1:0];
    s.lo = run_min[SampleBits-1:0];
    s.hi = run_max[SampleBits-1:0];
    s.total = run_sum[SumBits-1:0];
    s.mean = run_mean[MeanBits-1:0];
    if ((v >> (64 - FracBits)) != 0) s.std_dev = '1;
    else s.std_dev = StdBits'(floor_sqrt(v << FracBits));
    return s;
  endfunction

  task automatic compare_field(string tag, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, tag, want, got);
    end
  endtask

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    logic                         fire, nxt_valid, quiet;
    logic signed [SampleBits-1:0] nxt_sample;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_i <= '0;
    end else begin
      fire = in_valid_i && in_ready_o;
      if (fire) begin
        stats_due.push_back(welford_absorb(sample_i));
        samples_sent++;
      end
      nxt_valid = in_valid_i && !fire;
      nxt_sample = sample_i;
      quiet = (samples_sent >= CalmFirst && samples_sent < CalmLast);
      if (!nxt_valid && samples_pending.size() != 0 &&
          (quiet || $urandom_range(99) >= 15)) begin
        nxt_sample = samples_pending.pop_front();
        nxt_valid = 1'b1;
      end
      in_valid_i <= nxt_valid;
      sample_i <= nxt_sample;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    stats_t want;
    logic   quiet;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (stats_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request pending, count %0d", $time, sample_count_o);
        end else begin
          want = stats_due.pop_front();
          compare_field("sample_count", 64'(want.count), 64'(sample_count_o));
          compare_field("minimum", 64'(want.lo), 64'(minimum_o));
          compare_field("maximum", 64'(want.hi), 64'(maximum_o));
          compare_field("total", 64'(want.total), 64'(total_o));
          compare_field("mean", 64'(want.mean), 64'(mean_o));
          compare_field("std_dev", 64'(want.std_dev), 64'(std_dev_o));
        end
        stats_checked++;
      end
      quiet = (stats_checked >= CalmFirst && stats_checked < CalmLast);
      out_ready_i <= quiet || ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    logic signed [SampleBits-1:0] directed[$];
    logic signed [SampleBits-1:0] center;
    int unsigned                  pick;
    bit                           timed_out;
    // repeats first, so both deviation factors are zero for a while
    directed = '{16'sd100, 16'sd100, 16'sd100, 16'sd100, 16'sd100,
                 16'sh7fff, -16'sh8000, 16'sd0, -16'sd1, 16'sd1,
                 16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000, 16'sh5555,
                 16'shaaaa, 16'sd0, 16'sd0, -16'sd3, 16'sd2, 16'sd7, -16'sd7};
    foreach (directed[i]) samples_pending.push_back(directed[i]);
    center = '0;
    for (int i = 0; i < RandomSamples; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        samples_pending.push_back(SampleBits'($urandom_range(65535)));
      end else if (pick < 75) begin
        // clustered values stress the truncated mean and small deviations
        if ($urandom_range(19) == 0) center = SampleBits'($urandom_range(65535));
        samples_pending.push_back(center + SampleBits'($urandom_range(8)) - 16'sd4);
      end else if (pick < 90) begin
        samples_pending.push_back(($urandom_range(1) != 0) ? 16'sh7fff : -16'sh8000);
      end else begin
        samples_pending.push_back(SampleBits'($urandom_range(7)) - 16'sd3);
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    timed_out = 1'b0;
    while (samples_pending.size() != 0 || in_valid_i || stats_due.size() != 0) begin
      @(negedge clk_i);
      if (quiet_cycles >= QuietLimit) begin
        timed_out = 1'b1;
        break;
      end
    end

    if (timed_out) begin
      $display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
      $display("running_mean_variance_stats_top test failed");
    end else begin
      repeat (TailCycles) @(negedge clk_i);
      $display("sent %0d samples (extremes, repeats, clusters, full range)", samples_sent);
      $display("checked %0d statistics results, %0d mismatches", stats_checked, mismatches);
      if (mismatches == 0 && stats_due.size() == 0) begin
        $display("running_mean_variance_stats_top test passed");
      end else begin
        $display("running_mean_variance_stats_top test failed");
      end
    end
    $finish;
  end

endmodule
